[hdl/bdr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdr_pkg
// Shared types, register indexes and helper functions for the brightness
// dim regulator.
// ----------------------------------------------------------------------------
package bdr_pkg;

	localparam int unsigned LUX_W  = 16;
	localparam int unsigned TGT_W  = 12;
	localparam int unsigned LVL_W  = 8;
	localparam int unsigned ALU_W  = 17;
	localparam int unsigned CFG_W  = 8;
	localparam int unsigned IDX_W  = 2;
	localparam int unsigned PROD_W = 2 * TGT_W;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_SETPOINT = 2'd0;
	localparam logic [IDX_W-1:0] REG_HMODE    = 2'd1;
	localparam logic [IDX_W-1:0] REG_STEP     = 2'd2;

	// Hysteresis modes
	localparam logic [2:0] HMODE_DIV1  = 3'd0;
	localparam logic [2:0] HMODE_DIV2  = 3'd1;
	localparam logic [2:0] HMODE_DIV10 = 3'd2;
	localparam logic [2:0] HMODE_DIV5  = 3'd3;
	localparam logic [2:0] HMODE_DIV3  = 3'd4;

	// Reciprocals for the hysteresis divisions, scaled by 2^RECIP_SH
	localparam logic [TGT_W-1:0] RECIP5   = 12'd1639;
	localparam logic [TGT_W-1:0] RECIP3   = 12'd2731;
	localparam int unsigned      RECIP_SH = 13;

	// Shared unit operations
	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	typedef struct packed {
		logic             op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic             flag;   // carry on add, borrow on subtract
		logic [ALU_W-1:0] res;
	} alu_rsp_t;

	// Hysteresis: target divided by 1, 2, 10, 5 or 3; unused modes behave as
	// mode zero. Reciprocal products are exact for targets up to 2550.
	function automatic logic [TGT_W-1:0] hyst_quot(input logic [TGT_W-1:0] tgt,
	                                               input logic [2:0] mode);
		logic [PROD_W-1:0] p5;
		logic [PROD_W-1:0] p3;
		logic [TGT_W-1:0]  q;
		p5 = PROD_W'(tgt) * PROD_W'(RECIP5);
		p3 = PROD_W'(tgt) * PROD_W'(RECIP3);
		unique case (mode)
			HMODE_DIV2:  q = {1'b0, tgt[TGT_W-1:1]};
			HMODE_DIV10: q = TGT_W'(p5[PROD_W-1:RECIP_SH+1]);
			HMODE_DIV5:  q = TGT_W'(p5[PROD_W-1:RECIP_SH]);
			HMODE_DIV3:  q = TGT_W'(p3[PROD_W-1:RECIP_SH]);
			default:     q = tgt;
		endcase
		return q;
	endfunction

	// Large step: (code + 1) * 16, wrapping at eight bits
	function automatic logic [LVL_W-1:0] big_step(input logic [3:0] code);
		logic [3:0] c1;
		c1 = code + 4'd1;
		return {c1, 4'b0000};
	endfunction

endpackage

[hdl/brightness_dim_regulator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brightness_dim_regulator_core
// Brightness regulator: each lux request moves an 8-bit dim level toward the
// setpoint, with hysteresis and large or small steps, under a sequencer that
// drives one shared add/subtract unit.
// ----------------------------------------------------------------------------
// Each accepted request passes through the ten sequencer steps (target,
//   hysteresis, lower bound, four compares, two updates, output) and returns
//   to idle, where the next request is taken; no new request is accepted
//   until then. A stalled output holds the sequencer in the output step.
// The next request is taken while a finished result still waits downstream.
// Reset (arst_n low, asynchronous): dim level, configuration and output valid
//   clear, sequencer idle, no result pending; datapath registers not reset.
// ----------------------------------------------------------------------------
module brightness_dim_regulator_core import bdr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	// sample channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [LUX_W-1:0]   lux_sample,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [LVL_W-1:0]   dim_level,
	output logic               level_changed
);

	// Sequencer codes
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_TGT   = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_LOW   = 4'd3;
	localparam logic [3:0] ST_ABOVE = 4'd4;
	localparam logic [3:0] ST_FARA  = 4'd5;
	localparam logic [3:0] ST_BELOW = 4'd6;
	localparam logic [3:0] ST_FARB  = 4'd7;
	localparam logic [3:0] ST_UPD1  = 4'd8;
	localparam logic [3:0] ST_UPD2  = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	// Configuration registers
	logic [7:0]        setpoint_q;
	logic [2:0]        hmode_q;
	logic [3:0]        step_q;

	// Sequencer and working registers
	logic [3:0]        state_q;
	logic [LUX_W-1:0]  lux_q;
	logic [TGT_W-1:0]  tgt_q;
	logic [TGT_W-1:0]  quo_q;
	logic [TGT_W-1:0]  low_q;
	logic              above_q;
	logic              far_a_q;
	logic              below_q;
	logic              far_b_q;
	logic [LVL_W-1:0]  r1_q;
	logic              ok1_q;
	logic [LVL_W-1:0]  r2_q;
	logic              ok2_q;
	logic [LVL_W-1:0]  dim_q;

	// Output register
	logic              out_valid_q;
	logic [LVL_W-1:0]  out_level_q;
	logic              out_changed_q;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	logic [LVL_W-1:0]  big;
	logic [TGT_W-1:0]  hyst;
	logic [LVL_W-1:0]  new_dim;
	logic              in_take;
	logic              out_free;

	assign big      = big_step(step_q);
	// Hysteresis never drops below one
	assign hyst     = (quo_q == '0) ? TGT_W'(1) : quo_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Operand selection for the shared unit, at most one operation per step
	always_comb begin
		alu_req = '{op: ALU_ADD, a: '0, b: '0};
		unique case (state_q)
			ST_TGT: begin
				// target = setpoint*8 + setpoint*2
				alu_req.a = ALU_W'({setpoint_q, 3'b000});
				alu_req.b = ALU_W'({setpoint_q, 1'b0});
			end
			ST_LOW: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = ALU_W'(tgt_q);
				alu_req.b  = ALU_W'(hyst);
			end
			ST_ABOVE: begin
				// borrow means sample above target
				alu_req.op = ALU_SUB;
				alu_req.a  = ALU_W'(tgt_q);
				alu_req.b  = ALU_W'(lux_q);
			end
			ST_FARA: begin
				// borrow means sample above twice the target
				alu_req.op = ALU_SUB;
				alu_req.a  = ALU_W'({tgt_q, 1'b0});
				alu_req.b  = ALU_W'(lux_q);
			end
			ST_BELOW: begin
				// borrow means sample below the lower bound
				alu_req.op = ALU_SUB;
				alu_req.a  = ALU_W'(lux_q);
				alu_req.b  = ALU_W'(low_q);
			end
			ST_FARB: begin
				// borrow means twice the sample still below the lower bound
				alu_req.op = ALU_SUB;
				alu_req.a  = {lux_q, 1'b0};
				alu_req.b  = ALU_W'(low_q);
			end
			ST_UPD1: begin
				alu_req.op = above_q ? ALU_SUB : ALU_ADD;
				alu_req.a  = ALU_W'(dim_q);
				alu_req.b  = ALU_W'(big);
			end
			ST_UPD2: begin
				alu_req.op = above_q ? ALU_SUB : ALU_ADD;
				alu_req.a  = ALU_W'(dim_q);
				alu_req.b  = ALU_W'(4);
			end
			default: begin
			end
		endcase
	end

	bdr_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Pick the new level: large step if far and in range, else small step,
	// else saturate; hold when inside the dead band.
	always_comb begin
		new_dim = dim_q;
		if (above_q) begin
			if (far_a_q && ok1_q) begin
				new_dim = r1_q;
			end else if (ok2_q) begin
				new_dim = r2_q;
			end else begin
				new_dim = '0;
			end
		end else if (below_q) begin
			if (far_b_q && ok1_q) begin
				new_dim = r1_q;
			end else if (ok2_q) begin
				new_dim = r2_q;
			end else begin
				new_dim = '1;
			end
		end
	end

	// Configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			hmode_q    <= '0;
			step_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SETPOINT: setpoint_q <= cfg_data;
				REG_HMODE:    hmode_q    <= cfg_data[2:0];
				REG_STEP:     step_q     <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dim_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_TGT;
					end
				end
				ST_TGT:   state_q <= ST_DIV;
				ST_DIV:   state_q <= ST_LOW;
				ST_LOW:   state_q <= ST_ABOVE;
				ST_ABOVE: state_q <= ST_FARA;
				ST_FARA:  state_q <= ST_BELOW;
				ST_BELOW: state_q <= ST_FARB;
				ST_FARB:  state_q <= ST_UPD1;
				ST_UPD1:  state_q <= ST_UPD2;
				ST_UPD2:  state_q <= ST_FIN;
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						dim_q       <= new_dim;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output valid: raise on a finished request, drop once it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					lux_q <= lux_sample;
				end
			end
			ST_TGT: begin
				tgt_q <= alu_rsp.res[TGT_W-1:0];
			end
			ST_DIV: begin
				// divide the target by the selected divisor (reciprocal multiply for 5, 10, 3)
				quo_q <= hyst_quot(tgt_q, hmode_q);
			end
			ST_LOW: begin
				// clamp the lower bound at zero
				low_q <= alu_rsp.flag ? '0 : alu_rsp.res[TGT_W-1:0];
			end
			ST_ABOVE: above_q <= alu_rsp.flag;
			ST_FARA:  far_a_q <= alu_rsp.flag;
			ST_BELOW: below_q <= alu_rsp.flag;
			ST_FARB:  far_b_q <= alu_rsp.flag;
			ST_UPD1: begin
				r1_q  <= alu_rsp.res[LVL_W-1:0];
				ok1_q <= above_q ? !alu_rsp.flag : !alu_rsp.res[LVL_W];
			end
			ST_UPD2: begin
				r2_q  <= alu_rsp.res[LVL_W-1:0];
				ok2_q <= above_q ? !alu_rsp.flag : !alu_rsp.res[LVL_W];
			end
			ST_FIN: begin
				if (out_free) begin
					out_level_q   <= new_dim;
					out_changed_q <= (new_dim != dim_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign dim_level     = out_level_q;
	assign level_changed = out_changed_q;

endmodule

[hdl/bdr_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdr_alu
// Shared add/subtract unit; the carry-out doubles as borrow for compares.
// ----------------------------------------------------------------------------
module bdr_alu import bdr_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [ALU_W:0] sum;

	always_comb begin
		if (req.op == ALU_SUB) begin
			sum = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			sum = {1'b0, req.a} + {1'b0, req.b};
		end
	end

	assign rsp.flag = sum[ALU_W];
	assign rsp.res  = sum[ALU_W-1:0];

endmodule
